/* rtl/scd_pkg.sv */
package scd_pkg;

    // default size of the configuration byte table
    localparam int CONFIG_ENTRIES_DEF = 64;

    // character codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_A_LOW  = 8'h61;
    localparam logic [7:0] CHAR_F_LOW  = 8'h66;
    localparam logic [7:0] CHAR_V      = 8'h56;
    localparam logic [7:0] CHAR_D      = 8'h44;
    localparam logic [7:0] CHAR_Y      = 8'h59;
    localparam logic [7:0] CHAR_H      = 8'h48;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_S      = 8'h53;

    // config index that reads back the layout version
    localparam logic [7:0] INDEX_LAYOUT = 8'hff;

    // hex digits expected after each command letter
    localparam logic [3:0] DIGITS_Y = 4'(3 * 2);
    localparam logic [3:0] DIGITS_H = 4'(4 * 2);
    localparam logic [3:0] DIGITS_G = 4'(1 * 2);
    localparam logic [3:0] DIGITS_S = 4'(2 * 2);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TERM,
        PH_HEX
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_V,
        CMD_D,
        CMD_Y,
        CMD_H,
        CMD_G,
        CMD_S
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_VERSION,
        KIND_STATUS,
        KIND_DATE,
        KIND_TIME,
        KIND_CREAD,
        KIND_CWRITE,
        KIND_ERROR
    } kind_t;

    // decoded command as it leaves the parser
    typedef struct packed {
        kind_t      kind;
        logic [7:0] field_a;
        logic [7:0] field_b;
        logic [7:0] field_c;
        logic [7:0] field_d;
    } rec_t;

    // table write request from the parser
    typedef struct packed {
        logic       en;
        logic [7:0] index;
        logic [7:0] data;
    } tbl_wr_t;

    function automatic logic [3:0] digits_needed(input cmd_t cmd);
        logic [3:0] n;
        unique case (cmd)
            CMD_Y:   n = DIGITS_Y;
            CMD_H:   n = DIGITS_H;
            CMD_G:   n = DIGITS_G;
            CMD_S:   n = DIGITS_S;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

    // 0..15 for a lower-case hex digit, bit 4 set otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
            v = 5'(b - CHAR_ZERO);
        else if (b >= CHAR_A_LOW && b <= CHAR_F_LOW)
            v = 5'(b - CHAR_A_LOW + 8'd10);
        else
            v = 5'h10;
        return v;
    endfunction

endpackage

/* rtl/scd_parser.sv */
module scd_parser
    import scd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output logic       rec_valid,
    output rec_t       rec,
    output tbl_wr_t    tbl_wr
);

    phase_t     phase_reg, phase_next;
    cmd_t       cmd_reg, cmd_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] field_reg [4];
    logic [7:0] field_next [4];

    logic [7:0] b;
    logic [4:0] hex;
    logic [3:0] needed;
    logic [1:0] slot;
    logic [3:0] count_inc;

    assign b         = (rx_byte == CHAR_CR) ? CHAR_LF : rx_byte;
    assign hex       = hex_value(b);
    assign needed    = digits_needed(cmd_reg);
    assign slot      = count_reg[2:1];
    assign count_inc = count_reg + 4'd1;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= CMD_NONE;
            count_reg <= 4'd0;
            for (int i = 0; i < 4; i++)
            begin
                field_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            for (int i = 0; i < 4; i++)
            begin
                field_reg[i] <= field_next[i];
            end
        end
    end

    // one step per received word
    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        field_next  = field_reg;
        rec_valid   = 1'b0;
        rec.kind    = KIND_VERSION;
        rec.field_a = 8'd0;
        rec.field_b = 8'd0;
        rec.field_c = 8'd0;
        rec.field_d = 8'd0;
        tbl_wr.en    = 1'b0;
        tbl_wr.index = field_reg[0];
        tbl_wr.data  = field_reg[1];

        if (byte_en && rx_byte != CHAR_NUL)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    count_next = 4'd0;
                    unique case (b)
                        CHAR_V:
                        begin
                            cmd_next   = CMD_V;
                            phase_next = PH_TERM;
                        end
                        CHAR_D:
                        begin
                            cmd_next   = CMD_D;
                            phase_next = PH_TERM;
                        end
                        CHAR_Y:
                        begin
                            cmd_next   = CMD_Y;
                            phase_next = PH_HEX;
                        end
                        CHAR_H:
                        begin
                            cmd_next   = CMD_H;
                            phase_next = PH_HEX;
                        end
                        CHAR_G:
                        begin
                            cmd_next   = CMD_G;
                            phase_next = PH_HEX;
                        end
                        CHAR_S:
                        begin
                            cmd_next   = CMD_S;
                            phase_next = PH_HEX;
                        end
                        default:
                        begin
                            cmd_next = cmd_reg;
                        end
                    endcase
                end

                PH_HEX:
                begin
                    if (hex[4] || needed == 4'd0)
                    begin
                        // bad digit breaks the command
                        phase_next = PH_IDLE;
                        cmd_next   = CMD_NONE;
                        count_next = 4'd0;
                        rec_valid  = 1'b1;
                        rec.kind   = KIND_ERROR;
                    end
                    else
                    begin
                        // high nibble on even digits, low nibble added on odd
                        for (int i = 0; i < 4; i++)
                        begin
                            if (2'(i) == slot)
                            begin
                                field_next[i] = count_reg[0]
                                    ? field_reg[i] + {4'd0, hex[3:0]}
                                    : {hex[3:0], 4'd0};
                            end
                        end
                        count_next = count_inc;
                        if (count_inc >= needed)
                        begin
                            phase_next = PH_TERM;
                        end
                    end
                end

                PH_TERM:
                begin
                    phase_next = PH_IDLE;
                    cmd_next   = CMD_NONE;
                    count_next = 4'd0;
                    if (b != CHAR_LF)
                    begin
                        // wrong terminator is an error only for digit commands
                        if (cmd_reg == CMD_Y || cmd_reg == CMD_H ||
                            cmd_reg == CMD_G || cmd_reg == CMD_S)
                        begin
                            rec_valid = 1'b1;
                            rec.kind  = KIND_ERROR;
                        end
                    end
                    else
                    begin
                        unique case (cmd_reg)
                            CMD_V:
                            begin
                                rec_valid = 1'b1;
                                rec.kind  = KIND_VERSION;
                            end
                            CMD_D:
                            begin
                                rec_valid = 1'b1;
                                rec.kind  = KIND_STATUS;
                            end
                            CMD_Y:
                            begin
                                rec_valid   = 1'b1;
                                rec.kind    = KIND_DATE;
                                rec.field_a = field_reg[0];
                                rec.field_b = field_reg[1];
                                rec.field_c = field_reg[2];
                            end
                            CMD_H:
                            begin
                                rec_valid   = 1'b1;
                                rec.kind    = KIND_TIME;
                                rec.field_a = field_reg[0];
                                rec.field_b = field_reg[1];
                                rec.field_c = field_reg[2];
                                rec.field_d = field_reg[3];
                            end
                            CMD_G:
                            begin
                                rec_valid   = 1'b1;
                                rec.kind    = KIND_CREAD;
                                rec.field_a = field_reg[0];
                            end
                            CMD_S:
                            begin
                                rec_valid   = 1'b1;
                                rec.kind    = KIND_CWRITE;
                                rec.field_a = field_reg[0];
                                rec.field_b = field_reg[1];
                                tbl_wr.en   = 1'b1;
                            end
                            default:
                            begin
                                rec_valid = 1'b0;
                            end
                        endcase
                    end
                end

                default:
                begin
                    phase_next = PH_IDLE;
                    cmd_next   = CMD_NONE;
                    count_next = 4'd0;
                end
            endcase
        end
    end

    // idle parser never holds a partial digit count
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> count_reg == 4'd0)
        else $error("digit count left over in idle phase");

    // digit phase stays below the length of the command
    a_hex_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEX |-> count_reg < digits_needed(cmd_reg))
        else $error("digit count past the command length");

    // terminator after digits only once all digits are in
    a_term_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TERM && digits_needed(cmd_reg) != 4'd0)
            |-> count_reg == digits_needed(cmd_reg))
        else $error("terminator phase reached with digits missing");

endmodule

/* rtl/scd_cfg_table.sv */
module scd_cfg_table
    import scd_pkg::*;
#(
    parameter int CONFIG_ENTRIES = CONFIG_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  tbl_wr_t    wr,
    input  logic       rd_en,
    input  logic [7:0] rd_index,
    output logic [7:0] rd_data
);

    localparam int AW = (CONFIG_ENTRIES > 1) ? $clog2(CONFIG_ENTRIES) : 1;

    logic [7:0]                mem [CONFIG_ENTRIES];
    logic [CONFIG_ENTRIES-1:0] valid_reg;
    logic [7:0]                rd_data_reg;
    logic                      rd_hit_reg;

    logic          wr_in_range;
    logic          rd_in_range;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_in_range = {1'b0, wr.index} < 9'(CONFIG_ENTRIES);
    assign rd_in_range = {1'b0, rd_index} < 9'(CONFIG_ENTRIES);
    assign wr_addr     = wr.index[AW-1:0];
    assign rd_addr     = rd_index[AW-1:0];

    // table storage
    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en && rd_in_range)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries written since reset; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_in_range)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : 8'd0;

endmodule

/* rtl/serial_command_decoder.sv */
// Serial command decoder.
// Input channel: one received byte per word on rx_byte, handshake rx_valid and
// rx_stall. NUL bytes are taken and ignored, CR counts as LF. Commands are a
// letter, a fixed count of lower-case hex digits, then LF.
// Result channel: one word per finished or broken command on kind, field_a to
// field_d, reply_value, table_written and index_bad, handshake res_valid and
// res_stall. Bytes that finish nothing give no word.
// Latency: the result word is valid in the cycle after its terminating byte
// is taken. Throughput: one byte per cycle while rx_stall is low; the parser
// step and the table read both complete at the edge that loads the result register.
// Config: cfg_wr_en with cfg_wr_data sets the layout version read at index
// 0xff; write only while no command is in flight.
// Reset: parser idle, layout version 0, all table entries read as 0 (per-entry
// valid flags cleared at once, no clearing pass).
// Stall: while res_stall holds a waiting word, rx_stall is raised and no
// byte is taken; a free result register takes a byte in the same cycle.
module serial_command_decoder
    import scd_pkg::*;
#(
    parameter int CONFIG_ENTRIES = CONFIG_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [2:0] kind,
    output logic [7:0] field_a,
    output logic [7:0] field_b,
    output logic [7:0] field_c,
    output logic [7:0] field_d,
    output logic [7:0] reply_value,
    output logic       table_written,
    output logic       index_bad
);

    logic       layout_sel;
    logic [7:0] layout_version_reg;
    logic       out_valid_reg;
    rec_t       out_rec_reg;

    logic       load_ok;
    logic       byte_en;
    logic       rec_valid;
    rec_t       rec;
    tbl_wr_t    tbl_wr;
    logic [7:0] rd_data;
    logic       in_range;

    // result register free or being emptied
    assign load_ok  = !out_valid_reg || !res_stall;
    assign rx_stall = !load_ok;
    assign byte_en  = rx_valid && load_ok;

    scd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .rx_byte   (rx_byte),
        .rec_valid (rec_valid),
        .rec       (rec),
        .tbl_wr    (tbl_wr)
    );

    scd_cfg_table #(
        .CONFIG_ENTRIES (CONFIG_ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_en    (rec_valid),
        .rd_index (rec.field_a),
        .rd_data  (rd_data)
    );

    // layout version register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_version_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            layout_version_reg <= cfg_wr_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            out_valid_reg <= byte_en && rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    // read-back and flags for config commands
    assign in_range   = {1'b0, out_rec_reg.field_a} < 9'(CONFIG_ENTRIES);
    assign layout_sel = out_rec_reg.field_a == INDEX_LAYOUT;

    always_comb
    begin
        reply_value   = 8'd0;
        table_written = 1'b0;
        index_bad     = 1'b0;
        unique case (out_rec_reg.kind)
            KIND_CREAD:
            begin
                if (layout_sel)
                    reply_value = layout_version_reg;
                else if (in_range)
                    reply_value = rd_data;
                else
                    index_bad = 1'b1;
            end
            KIND_CWRITE:
            begin
                if (in_range)
                begin
                    table_written = 1'b1;
                    reply_value   = out_rec_reg.field_b;
                end
                else if (layout_sel)
                    reply_value = layout_version_reg;
                else
                    index_bad = 1'b1;
            end
            default:
            begin
                reply_value = 8'd0;
            end
        endcase
    end

    assign res_valid = out_valid_reg;
    assign kind      = out_rec_reg.kind;
    assign field_a   = out_rec_reg.field_a;
    assign field_b   = out_rec_reg.field_b;
    assign field_c   = out_rec_reg.field_c;
    assign field_d   = out_rec_reg.field_d;

    // a taken byte that finishes a command shows up next cycle
    a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_en && rec_valid) |=> res_valid)
        else $error("finished command did not reach the result register");

    // only an in-range config write touches the table
    a_written_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && table_written) |-> (kind == KIND_CWRITE && !index_bad))
        else $error("table write flagged on a word that is no valid write");

    // a bad index reads back zero and only on config commands
    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && index_bad)
            |-> (reply_value == 8'd0 && (kind == KIND_CREAD || kind == KIND_CWRITE)))
        else $error("bad index with nonzero reply or wrong kind");

endmodule

/* tb/sv/serial_command_decoder_checker.sv */
module serial_command_decoder_checker
    import scd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       rx_valid,
    input  logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       res_valid,
    input  logic       res_stall,
    input  logic [2:0] kind,
    input  logic [7:0] field_a,
    input  logic [7:0] field_b,
    input  logic [7:0] field_c,
    input  logic [7:0] field_d,
    input  logic [7:0] reply_value,
    input  logic       table_written,
    input  logic       index_bad,
    output int         n_pending,
    output int         n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // one decoded command word as it should leave the block
    typedef struct packed {
        kind_t      kind;
        logic [7:0] fa;
        logic [7:0] fb;
        logic [7:0] fc;
        logic [7:0] fd;
        logic [7:0] reply;
        logic       written;
        logic       bad;
    } cmd_word_t;

    // parser and table shadow
    phase_t     parse_phase;
    cmd_t       cur_cmd;
    logic [3:0] n_digits;
    logic [3:0] n_target;
    logic [7:0] fbytes [4];
    logic [7:0] cfg_table [CONFIG_ENTRIES_DEF];
    logic [7:0] layout_ver;
    cmd_word_t  pending_words [$];
    int         err_count;

    // config byte read back for G and S
    function automatic logic [7:0] table_lookup(input logic [7:0] idx, output logic bad);
        bad = 1'b0;
        if (idx == INDEX_LAYOUT)
            return layout_ver;
        if (idx < CONFIG_ENTRIES_DEF)
            return cfg_table[idx];
        bad = 1'b1;
        return 8'h00;
    endfunction

    task automatic go_idle();
        parse_phase = PH_IDLE;
        cur_cmd     = CMD_NONE;
        n_digits    = 4'd0;
    endtask

    // advance the parser by one received byte, queue the word it completes
    task automatic decode_byte(input logic [7:0] raw);
        logic [7:0] b;
        logic [3:0] nib;
        logic       is_hex;
        logic [1:0] slot;
        cmd_t       cmd;
        cmd_word_t  w;
        if (raw == CHAR_NUL)
            return;
        b = (raw == CHAR_CR) ? CHAR_LF : raw;
        w = '0;
        is_hex = 1'b0;
        nib = 4'd0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            is_hex = 1'b1;
            nib = b[3:0];
        end
        else if (b >= CHAR_A_LOW && b <= CHAR_F_LOW) begin
            is_hex = 1'b1;
            nib = b[3:0] + 4'd9;
        end

        case (parse_phase)
            PH_IDLE:
            begin
                case (b)
                    CHAR_V: begin cur_cmd = CMD_V; n_target = 4'd0; parse_phase = PH_TERM; end
                    CHAR_D: begin cur_cmd = CMD_D; n_target = 4'd0; parse_phase = PH_TERM; end
                    CHAR_Y: begin cur_cmd = CMD_Y; n_target = 4'd6; parse_phase = PH_HEX; end
                    CHAR_H: begin cur_cmd = CMD_H; n_target = 4'd8; parse_phase = PH_HEX; end
                    CHAR_G: begin cur_cmd = CMD_G; n_target = 4'd2; parse_phase = PH_HEX; end
                    CHAR_S: begin cur_cmd = CMD_S; n_target = 4'd4; parse_phase = PH_HEX; end
                    default: ;
                endcase
                n_digits = 4'd0;
            end
            PH_HEX:
            begin
                if (!is_hex || n_target == 4'd0) begin
                    go_idle();
                    w.kind = KIND_ERROR;
                    pending_words.push_back(w);
                end
                else begin
                    slot = n_digits[2:1];
                    if (n_digits[0])
                        fbytes[slot] = fbytes[slot] + {4'h0, nib};
                    else
                        fbytes[slot] = {nib, 4'h0};
                    n_digits = n_digits + 4'd1;
                    if (n_digits >= n_target)
                        parse_phase = PH_TERM;
                end
            end
            default:
            begin
                cmd = cur_cmd;
                go_idle();
                if (b != CHAR_LF) begin
                    // broken terminator: only digit commands report it
                    if (!(cmd inside {CMD_V, CMD_D, CMD_NONE})) begin
                        w.kind = KIND_ERROR;
                        pending_words.push_back(w);
                    end
                end
                else begin
                    case (cmd)
                        CMD_V: begin w.kind = KIND_VERSION; pending_words.push_back(w); end
                        CMD_D: begin w.kind = KIND_STATUS; pending_words.push_back(w); end
                        CMD_Y:
                        begin
                            w.kind = KIND_DATE;
                            w.fa = fbytes[0];
                            w.fb = fbytes[1];
                            w.fc = fbytes[2];
                            pending_words.push_back(w);
                        end
                        CMD_H:
                        begin
                            w.kind = KIND_TIME;
                            w.fa = fbytes[0];
                            w.fb = fbytes[1];
                            w.fc = fbytes[2];
                            w.fd = fbytes[3];
                            pending_words.push_back(w);
                        end
                        CMD_G:
                        begin
                            w.kind = KIND_CREAD;
                            w.fa = fbytes[0];
                            w.reply = table_lookup(fbytes[0], w.bad);
                            pending_words.push_back(w);
                        end
                        CMD_S:
                        begin
                            w.kind = KIND_CWRITE;
                            w.fa = fbytes[0];
                            w.fb = fbytes[1];
                            if (fbytes[0] < CONFIG_ENTRIES_DEF) begin
                                cfg_table[fbytes[0]] = fbytes[1];
                                w.written = 1'b1;
                            end
                            w.reply = table_lookup(fbytes[0], w.bad);
                            pending_words.push_back(w);
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // compare one result word with the oldest prediction
    task automatic check_word();
        cmd_word_t w;
        if (pending_words.size() == 0) begin
            $error("unexpected result word: kind %0d field_a %0d", kind, field_a);
            err_count++;
            return;
        end
        w = pending_words.pop_front();
        check_field("kind", int'(w.kind), int'(kind));
        check_field("field_a", w.fa, field_a);
        check_field("field_b", w.fb, field_b);
        check_field("field_c", w.fc, field_c);
        check_field("field_d", w.fd, field_d);
        check_field("reply_value", w.reply, reply_value);
        check_field("table_written", w.written, table_written);
        check_field("index_bad", w.bad, index_bad);
    endtask

    // watch both channels and the config port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            go_idle();
            n_target   = 4'd0;
            layout_ver = 8'h00;
            for (int i = 0; i < 4; i++)
                fbytes[i] = 8'h00;
            for (int i = 0; i < CONFIG_ENTRIES_DEF; i++)
                cfg_table[i] = 8'h00;
            pending_words.delete();
            err_count = 0;
            n_pending <= 0;
            n_errors  <= 0;
        end
        else begin
            if (res_valid && !res_stall)
                check_word();
            if (cfg_wr_en)
                layout_ver = cfg_wr_data;
            if (rx_valid && !rx_stall)
                decode_byte(rx_byte);
            n_pending <= pending_words.size();
            n_errors  <= err_count;
        end
    end

endmodule

/* tb/sv/serial_command_decoder_test.sv */
module serial_command_decoder_test
    import scd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] field_a;
    logic [7:0] field_b;
    logic [7:0] field_c;
    logic [7:0] field_d;
    logic [7:0] reply_value;
    logic       table_written;
    logic       index_bad;
    int         n_pending;
    int         n_errors;

    int         cycles = 0;
    int         bytes_sent = 0;
    bit         rx_gaps = 1'b1;
    bit         stall_on = 1'b1;
    bit         nul_mix = 1'b0;

    // command letters and the hex bytes each one carries
    logic [7:0] letters [6];
    int         nbytes_of [6];

    serial_command_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .field_a       (field_a),
        .field_b       (field_b),
        .field_c       (field_c),
        .field_d       (field_d),
        .reply_value   (reply_value),
        .table_written (table_written),
        .index_bad     (index_bad)
    );

    serial_command_decoder_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rx_valid      (rx_valid),
        .rx_stall      (rx_stall),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .kind          (kind),
        .field_a       (field_a),
        .field_b       (field_b),
        .field_c       (field_c),
        .field_d       (field_d),
        .reply_value   (reply_value),
        .table_written (table_written),
        .index_bad     (index_bad),
        .n_pending     (n_pending),
        .n_errors      (n_errors)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_A_LOW + 8'(n - 4'd10);
    endfunction

    // one word on the rx channel, with an optional gap in front
    task automatic push_byte(input logic [7:0] b);
        if (rx_gaps && $urandom_range(0, 5) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (rx_stall);
        bytes_sent++;
    endtask

    // byte with an occasional NUL slipped in ahead
    task automatic send_byte(input logic [7:0] b);
        if (nul_mix && $urandom_range(0, 15) == 0)
            push_byte(CHAR_NUL);
        push_byte(b);
    endtask

    // letter, hex bytes from the top of payload, terminator
    task automatic send_cmd(input logic [7:0] letter, input logic [31:0] payload,
                            input int nbytes, input logic [7:0] term);
        send_byte(letter);
        for (int i = 0; i < nbytes; i++)
        begin
            send_byte(hex_char(payload[31 - 8 * i -: 4]));
            send_byte(hex_char(payload[27 - 8 * i -: 4]));
        end
        send_byte(term);
    endtask

    // bring the parser idle and wait until every word is out
    task automatic settle();
        push_byte(CHAR_LF);
        rx_valid <= 1'b0;
        do @(posedge clk); while (n_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_layout(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly well-formed commands, some noise and broken ones
    task automatic rand_command();
        int          pick;
        int          i;
        int          k;
        logic [31:0] pay;
        logic [7:0]  term;
        logic [7:0]  idx;
        pick = $urandom_range(0, 99);
        pay  = $urandom;
        term = $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
        k = $urandom_range(0, 9);
        if (k < 7)
            idx = 8'($urandom_range(0, CONFIG_ENTRIES_DEF - 1));
        else if (k == 7)
            idx = INDEX_LAYOUT;
        else
            idx = 8'($urandom_range(CONFIG_ENTRIES_DEF, 254));

        if (pick < 85)
        begin
            i = $urandom_range(0, 5);
            if (i >= 4)
                pay[31:24] = idx;
            send_cmd(letters[i], pay, nbytes_of[i], term);
        end
        else if (pick < 91)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            // digits cut short by an arbitrary byte
            i = $urandom_range(2, 5);
            send_byte(letters[i]);
            for (k = $urandom_range(0, 2 * nbytes_of[i] - 1); k > 0; k--)
                send_byte(hex_char(4'($urandom_range(0, 15))));
            send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            i = $urandom_range(0, 5);
            if (i >= 4)
                pay[31:24] = idx;
            send_cmd(letters[i], pay, nbytes_of[i], 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int goal;
        letters   = '{CHAR_V, CHAR_D, CHAR_Y, CHAR_H, CHAR_G, CHAR_S};
        nbytes_of = '{0, 0, 3, 4, 1, 2};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_layout(8'hff);

        // directed commands and corner cases
        send_cmd(CHAR_V, 32'h0, 0, CHAR_LF);
        send_cmd(CHAR_D, 32'h0, 0, CHAR_CR);
        send_cmd(CHAR_Y, 32'h000c1f00, 3, CHAR_LF);
        send_cmd(CHAR_H, 32'hffffffff, 4, CHAR_CR);
        send_cmd(CHAR_H, 32'h00000000, 4, CHAR_LF);
        send_cmd(CHAR_S, 32'h3fa50000, 2, CHAR_LF);
        send_cmd(CHAR_S, 32'h00ff0000, 2, CHAR_LF);
        send_cmd(CHAR_G, 32'h3f000000, 1, CHAR_LF);
        send_cmd(CHAR_G, 32'h05000000, 1, CHAR_LF);
        // index out of range, then the layout index
        send_cmd(CHAR_S, 32'h40110000, 2, CHAR_LF);
        send_cmd(CHAR_G, 32'hfe000000, 1, CHAR_LF);
        send_cmd(CHAR_G, 32'hff000000, 1, CHAR_LF);
        send_cmd(CHAR_S, 32'hff770000, 2, CHAR_LF);
        // NUL inside a command is skipped
        send_byte(CHAR_G);
        push_byte(CHAR_NUL);
        send_byte("3");
        send_byte("f");
        push_byte(CHAR_NUL);
        send_byte(CHAR_LF);
        // upper case and LF are bad digits
        send_byte(CHAR_G);
        send_byte("A");
        send_byte(CHAR_Y);
        send_byte(CHAR_LF);
        // wrong terminators
        send_cmd(CHAR_G, 32'h01000000, 1, "x");
        send_cmd(CHAR_V, 32'h0, 0, "q");
        // idle bytes that start nothing
        send_byte("z");
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(8'hff);
        // a letter where a digit belongs
        send_byte(CHAR_H);
        send_byte(CHAR_S);

        // random phases, each under its own layout version and idling mix
        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            if (ph == 0)
                write_layout(8'h00);
            else if (ph == 1)
                write_layout(8'hff);
            else
                write_layout(8'($urandom_range(0, 255)));
            rx_gaps  = (ph < 5) && (ph != 2);
            stall_on = (ph < 5) && (ph != 3);
            nul_mix  = (ph % 2) == 1;
            goal = bytes_sent + 220;
            while (bytes_sent < goal)
                rand_command();
        end

        settle();
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
